// ===== sv/asre_pkg.sv =====
// asre_pkg: shared types and constants of the advection stencil row engine
// holds field widths, scheme and register index codes, and the stage-one record
// no dependencies
`timescale 1ns / 1ps

package asre_pkg;

	localparam int DATA_W    = 32;
	localparam int COL_W     = 10;
	localparam int S_TDATA_W = 64;
	localparam int M_TDATA_W = 48;
	localparam int SUM_W     = 56;

	// scheme_mode codes
	localparam logic [1:0] MODE_UPWIND = 2'd0;
	localparam logic [1:0] MODE_LW     = 2'd1;
	localparam logic [1:0] MODE_LF     = 2'd2;
	localparam logic [1:0] MODE_LEAP   = 2'd3;

	// configuration register indexes
	localparam logic [2:0] REG_SCHEME_MODE  = 3'd0;
	localparam logic [2:0] REG_TIME_STEP    = 3'd1;
	localparam logic [2:0] REG_COURANT      = 3'd2;
	localparam logic [2:0] REG_HALF_COURANT = 3'd3;
	localparam logic [2:0] REG_ROW_LENGTH   = 3'd4;

	typedef struct packed {
		logic signed [DATA_W-1:0] ur;
		logic signed [DATA_W-1:0] uc;
		logic signed [DATA_W-1:0] ul;
		logic signed [DATA_W-1:0] f;
		logic [1:0]               mode;
		logic [COL_W-1:0]         col_idx;
		logic                     last;
	} asre_s1_t;

endpackage

// ===== sv/asre_row_store.sv =====
// asre_row_store: previous-row store, one read-modify-write port
// registered read returns the old entry when read and write share an address
// no dependencies
`timescale 1ns / 1ps

module asre_row_store #(
	parameter int DEPTH  = 1024,
	parameter int ADDR_W = 10,
	parameter int WIDTH  = 32
) (
	input  logic              clk,
	input  logic              rd_en,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] addr,
	input  logic [WIDTH-1:0]  wr_data,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[addr];
		end
		if (wr_en) begin
			mem[addr] <= wr_data;
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== sv/asre_front.sv =====
// asre_front: column tracking, point window and stage-one register
// depends on asre_pkg and asre_row_store
`timescale 1ns / 1ps

module asre_front #(
	parameter int ROW_MAX = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [asre_pkg::DATA_W-1:0] point_value,
	input  logic signed [asre_pkg::DATA_W-1:0] source_value,
	input  logic                          grid_start,
	input  logic [1:0]                    scheme_mode,
	input  logic [10:0]                   row_length,
	input  logic                          s1_ready,
	output logic                          s1_valid,
	output asre_pkg::asre_s1_t            s1,
	output logic [asre_pkg::DATA_W-1:0]   old_value
);
	import asre_pkg::*;

	localparam int CNT_W = $clog2(ROW_MAX);
	localparam int LEN_W = (CNT_W + 1 > 11) ? CNT_W + 1 : 11;

	logic signed [DATA_W-1:0] left_q, center_q, source_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     older_q;
	logic                     valid_s1;
	asre_s1_t                 stage_s1;

	logic [LEN_W-1:0] len_raw, len_c;
	logic [CNT_W-1:0] len_m1, cnt_cur, col, m;
	logic             older_cur, has_res, accept, row_end;
	logic [1:0]       mode_eff;

	always_comb begin
		len_raw = LEN_W'(row_length);
		if (len_raw < LEN_W'(3)) begin
			len_c = LEN_W'(3);
		end else if (len_raw > LEN_W'(ROW_MAX)) begin
			len_c = LEN_W'(ROW_MAX);
		end else begin
			len_c = len_raw;
		end
		len_m1    = CNT_W'(len_c - LEN_W'(1));
		cnt_cur   = grid_start ? '0 : cnt_q;
		older_cur = grid_start ? 1'b0 : older_q;
		col       = (cnt_cur > len_m1) ? len_m1 : cnt_cur;
		has_res   = col >= CNT_W'(2);
		m         = col - CNT_W'(1);
		row_end   = col == len_m1;
		// leapfrog needs an older row
		mode_eff  = (scheme_mode == MODE_LEAP && !older_cur) ? MODE_UPWIND : scheme_mode;
	end

	assign in_ready = !valid_s1 || s1_ready;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= '0;
			center_q <= '0;
			source_q <= '0;
			cnt_q    <= '0;
			older_q  <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= accept && has_res;
			end
			if (accept) begin
				left_q   <= center_q;
				center_q <= point_value;
				source_q <= source_value;
				if (row_end) begin
					cnt_q   <= '0;
					older_q <= 1'b1;
				end else begin
					cnt_q   <= col + CNT_W'(1);
					older_q <= older_cur;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			stage_s1.ur      <= point_value;
			stage_s1.uc      <= center_q;
			stage_s1.ul      <= left_q;
			stage_s1.f       <= source_q;
			stage_s1.mode    <= mode_eff;
			stage_s1.col_idx <= COL_W'(m);
			stage_s1.last    <= row_end;
		end
	end

	asre_row_store #(
		.DEPTH  (ROW_MAX),
		.ADDR_W (CNT_W),
		.WIDTH  (DATA_W)
	) u_store (
		.clk     (clk),
		.rd_en   (accept),
		.wr_en   (accept && has_res),
		.addr    (m),
		.wr_data (center_q),
		.rd_data (old_value)
	);

	assign s1_valid = valid_s1;
	assign s1       = stage_s1;

endmodule

// ===== sv/asre_arith.sv =====
// asre_arith: product stage and sum/saturate stage with the result register
// depends on asre_pkg
`timescale 1ns / 1ps

module asre_arith #(
	parameter int FRACTION_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s1_valid,
	input  asre_pkg::asre_s1_t          s1,
	input  logic [asre_pkg::DATA_W-1:0] old_value,
	input  logic [16:0]                 time_step,
	input  logic [17:0]                 courant_ratio,
	input  logic [17:0]                 half_courant_squared,
	output logic                        s1_ready,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [asre_pkg::DATA_W-1:0] next_value,
	output logic [asre_pkg::COL_W-1:0]  column_index,
	output logic                        row_last
);
	import asre_pkg::*;

	logic signed [33:0] ur_x, uc_x, ul_x, d_h;
	logic signed [32:0] d_c, base;
	logic signed [49:0] p_t;
	logic signed [51:0] p_c;
	logic signed [52:0] p_h;

	logic               valid_s2, valid_s3, adv2, adv3;
	logic signed [49:0] p_t_s2;
	logic signed [51:0] p_c_s2;
	logic signed [52:0] p_h_s2;
	logic signed [32:0] base_s2;
	logic [1:0]         mode_s2;
	logic [COL_W-1:0]   col_s2;
	logic               last_s2;

	logic signed [SUM_W-1:0] t_term, c_term, h_term, r;
	logic [DATA_W-1:0]       sat;
	logic [DATA_W-1:0]       next_s3;
	logic [COL_W-1:0]        col_s3;
	logic                    last_s3;

	assign adv3     = !valid_s3 || out_ready;
	assign adv2     = !valid_s2 || adv3;
	assign s1_ready = adv2;

	always_comb begin
		ur_x = s1.ur;
		uc_x = s1.uc;
		ul_x = s1.ul;
		d_c  = (s1.mode == MODE_UPWIND) ? 33'(uc_x - ul_x) : 33'(ur_x - ul_x);
		d_h  = ur_x - (uc_x <<< 1) + ul_x;
		p_t  = $signed({1'b0, time_step}) * s1.f;
		p_c  = $signed({1'b0, courant_ratio}) * d_c;
		p_h  = $signed({1'b0, half_courant_squared}) * d_h;
		case (s1.mode)
			MODE_LF:   base = 33'((ur_x + ul_x) >>> 1);
			MODE_LEAP: base = $signed({old_value[DATA_W-1], old_value});
			default:   base = 33'(uc_x);
		endcase
	end

	always_comb begin
		// leapfrog doubles the source term: one bit less of shift
		t_term = (mode_s2 == MODE_LEAP) ? SUM_W'(p_t_s2 >>> (FRACTION_BITS - 1))
		                                : SUM_W'(p_t_s2 >>> FRACTION_BITS);
		c_term = (mode_s2 == MODE_UPWIND || mode_s2 == MODE_LEAP)
		       ? SUM_W'(p_c_s2 >>> FRACTION_BITS)
		       : SUM_W'(p_c_s2 >>> (FRACTION_BITS + 1));
		h_term = (mode_s2 == MODE_LW) ? SUM_W'(p_h_s2 >>> FRACTION_BITS) : '0;
		r      = SUM_W'(base_s2) + t_term - c_term + h_term;
		if (&r[SUM_W-1:DATA_W-1] || ~|r[SUM_W-1:DATA_W-1]) begin
			sat = r[DATA_W-1:0];
		end else if (r[SUM_W-1]) begin
			sat = {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			sat = {1'b0, {(DATA_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv2) begin
				valid_s2 <= s1_valid;
			end
			if (adv3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			p_t_s2  <= p_t;
			p_c_s2  <= p_c;
			p_h_s2  <= p_h;
			base_s2 <= base;
			mode_s2 <= s1.mode;
			col_s2  <= s1.col_idx;
			last_s2 <= s1.last;
		end
		if (adv3) begin
			next_s3 <= sat;
			col_s3  <= col_s2;
			last_s3 <= last_s2;
		end
	end

	assign out_valid    = valid_s3;
	assign next_value   = next_s3;
	assign column_index = col_s3;
	assign row_last     = last_s3;

endmodule

// ===== sv/advection_stencil_row_engine.sv =====
// advection_stencil_row_engine: top level, configuration registers and stream ports
// depends on asre_pkg, asre_front, asre_arith
`timescale 1ns / 1ps

// Usage:
// Grid points stream in on the s_ group in column order, one point with its
// source value per transfer; s_tuser flags the first point of a new grid.
// Each point from column 2 on yields one transfer on the m_ group: the
// next-row value of the column before, its column index, and tlast on the
// last interior column of the row. Columns 0 and 1 yield nothing.
// A result appears on m_tvalid once the point causing it has passed the three
// register stages (window/row-store read, products, sum and saturate); one point
// is taken every cycle while the receiver keeps up.
// When the receiver stalls, results hold in the stages and s_tready drops
// only once all three stages are full.
// The cfg port writes registers by index; write only while the block is idle.
// Reset clears the column counter, the point window, the older-row flag and
// the pipeline; no clearing pass runs, and the row store is undefined until a
// row has been written into it.
module advection_stencil_row_engine #(
	parameter int ROW_MAX       = 1024,
	parameter int FRACTION_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [asre_pkg::S_TDATA_W-1:0] s_tdata,  // point_value, source_value
	input  logic [0:0]                     s_tuser,  // grid_start
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [asre_pkg::M_TDATA_W-1:0] m_tdata,  // next_value, column_index, zero fill
	output logic                           m_tlast,
	input  logic                           cfg_wr_en,
	input  logic [2:0]                     cfg_index,
	input  logic [17:0]                    cfg_wdata
);
	import asre_pkg::*;

	localparam logic [16:0] TAU_RST  = 17'((64'd1 << FRACTION_BITS) / 100);
	localparam logic [17:0] C_RST    = 18'(64'd1 << FRACTION_BITS);
	localparam logic [17:0] HALF_RST = 18'(64'd1 << (FRACTION_BITS - 1));

	logic [1:0]  mode_q;
	logic [16:0] tau_q;
	logic [17:0] courant_q;
	logic [17:0] half_q;
	logic [10:0] len_q;

	logic              s1_valid, s1_ready;
	asre_s1_t          s1;
	logic [DATA_W-1:0] old_value, next_value;
	logic [COL_W-1:0]  column_index;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_UPWIND;
			tau_q     <= TAU_RST;
			courant_q <= C_RST;
			half_q    <= HALF_RST;
			len_q     <= 11'd1000;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_SCHEME_MODE:  mode_q    <= cfg_wdata[1:0];
				REG_TIME_STEP:    tau_q     <= cfg_wdata[16:0];
				REG_COURANT:      courant_q <= cfg_wdata;
				REG_HALF_COURANT: half_q    <= cfg_wdata;
				REG_ROW_LENGTH:   len_q     <= cfg_wdata[10:0];
				default: ;
			endcase
		end
	end

	asre_front #(
		.ROW_MAX (ROW_MAX)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.point_value  ($signed(s_tdata[31:0])),
		.source_value ($signed(s_tdata[63:32])),
		.grid_start   (s_tuser[0]),
		.scheme_mode  (mode_q),
		.row_length   (len_q),
		.s1_ready     (s1_ready),
		.s1_valid     (s1_valid),
		.s1           (s1),
		.old_value    (old_value)
	);

	asre_arith #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_arith (
		.clk                  (clk),
		.arst_n               (arst_n),
		.s1_valid             (s1_valid),
		.s1                   (s1),
		.old_value            (old_value),
		.time_step            (tau_q),
		.courant_ratio        (courant_q),
		.half_courant_squared (half_q),
		.s1_ready             (s1_ready),
		.out_valid            (m_tvalid),
		.out_ready            (m_tready),
		.next_value           (next_value),
		.column_index         (column_index),
		.row_last             (m_tlast)
	);

	assign m_tdata = {{(M_TDATA_W - DATA_W - COL_W){1'b0}}, column_index, next_value};

	// the first point of a grid is column 0 and never yields a result
	a_start_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser[0] |=> !s1_valid)
		else $error("grid start produced a stage-one result");

	// a stalled stage-one entry is not dropped
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid && !s1_ready |=> s1_valid && $stable(s1))
		else $error("stage-one entry lost or changed under stall");

	// input is refused only while stage one is full and stalled
	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> s1_valid && !s1_ready && m_tvalid && !m_tready)
		else $error("input refused with room in the pipeline");

endmodule

// ===== dv/testbench.sv =====
// testbench: self-checking bench for the advection stencil row engine
// predicts every next-row value from its own model of the four schemes
// depends on asre_pkg and advection_stencil_row_engine
`timescale 1ns / 1ps

module testbench;
	import asre_pkg::*;

	localparam int FRAC           = 16;
	localparam int ROW_MAX        = 1024;
	localparam int ITEM_TARGET    = 1950;
	localparam int LONG_HOLD      = 300;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES  = 10;
	localparam int MAX_REPORTS    = 100;

	localparam longint SAT_HI = 64'sh0000_0000_7FFF_FFFF;
	localparam longint SAT_LO = -SAT_HI - 1;

	typedef struct {
		logic signed [DATA_W-1:0] value;
		logic [COL_W-1:0]         column;
		logic                     row_end;
	} next_point_t;

	class stencil_scoreboard;
		logic [1:0]  scheme;
		logic [16:0] tau;
		logic [17:0] courant;
		logic [17:0] half_c2;
		logic [10:0] row_len;

		logic signed [DATA_W-1:0] left_pt;
		logic signed [DATA_W-1:0] center_pt;
		logic signed [DATA_W-1:0] center_src;
		int unsigned              next_col;
		bit                       older_valid;
		logic signed [DATA_W-1:0] older_row [ROW_MAX];

		next_point_t pending_next[$];
		int          errors;

		function new();
			scheme      = MODE_UPWIND;
			tau         = 17'd655;
			courant     = 18'd65536;
			half_c2     = 18'd32768;
			row_len     = 11'd1000;
			left_pt     = '0;
			center_pt   = '0;
			center_src  = '0;
			next_col    = 0;
			older_valid = 1'b0;
			errors      = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [17:0] val);
			case (idx)
				REG_SCHEME_MODE:  scheme  = val[1:0];
				REG_TIME_STEP:    tau     = val[16:0];
				REG_COURANT:      courant = val;
				REG_HALF_COURANT: half_c2 = val;
				REG_ROW_LENGTH:   row_len = val[10:0];
				default: ;
			endcase
		endfunction

		function int unsigned waiting();
			return pending_next.size();
		endfunction

		function void flag(string what, logic [63:0] want, logic [63:0] got);
			errors++;
			if (errors <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
		endfunction

		// one accepted point: advance the window and queue the next-row value it yields
		function void note_point(logic signed [DATA_W-1:0] ur, logic signed [DATA_W-1:0] fr,
				bit start);
			int unsigned len;
			int unsigned col;
			int unsigned m;
			longint      ul, uc, ur_w, t, c, hc, tf, r;
			logic [1:0]  mode;
			next_point_t want;
			len = row_len;
			if (len < 3)
				len = 3;
			if (len > ROW_MAX)
				len = ROW_MAX;
			if (start) begin
				next_col    = 0;
				older_valid = 1'b0;
			end
			col = (next_col >= len) ? len - 1 : next_col;
			if (col >= 2) begin
				m    = col - 1;
				ul   = left_pt;
				uc   = center_pt;
				ur_w = ur;
				t    = tau;
				c    = courant;
				hc   = half_c2;
				tf   = (t * longint'(center_src)) >>> FRAC;
				mode = scheme;
				// leapfrog needs a full previous row
				if (mode == MODE_LEAP && !older_valid)
					mode = MODE_UPWIND;
				case (mode)
					MODE_UPWIND: r = uc + tf - ((c * (uc - ul)) >>> FRAC);
					MODE_LW: r = uc + tf - ((c * (ur_w - ul)) >>> (FRAC + 1))
						+ ((hc * (ur_w - 2 * uc + ul)) >>> FRAC);
					MODE_LF: r = ((ur_w + ul) >>> 1) + tf - ((c * (ur_w - ul)) >>> (FRAC + 1));
					default: r = longint'(older_row[m])
						+ ((2 * t * longint'(center_src)) >>> FRAC)
						- ((c * (ur_w - ul)) >>> FRAC);
				endcase
				if (r > SAT_HI)
					want.value = SAT_HI[31:0];
				else if (r < SAT_LO)
					want.value = SAT_LO[31:0];
				else
					want.value = 32'(r);
				want.column  = COL_W'(m);
				want.row_end = (col == len - 1);
				pending_next.push_back(want);
				older_row[m] = center_pt;
			end
			left_pt    = center_pt;
			center_pt  = ur;
			center_src = fr;
			if (col >= len - 1) begin
				next_col    = 0;
				older_valid = 1'b1;
			end else
				next_col = col + 1;
		endfunction

		function void check_result(logic [M_TDATA_W-1:0] data, logic row_end);
			next_point_t want;
			if (pending_next.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: result with nothing pending, expected none, actual %0h",
						$time, data);
				return;
			end
			want = pending_next.pop_front();
			if (data[DATA_W-1:0] !== want.value)
				flag("next_value", want.value, data[DATA_W-1:0]);
			if (data[DATA_W +: COL_W] !== want.column)
				flag("column_index", want.column, data[DATA_W +: COL_W]);
			if (row_end !== want.row_end)
				flag("row_last", want.row_end, row_end);
		endfunction
	endclass

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata   = '0;
	logic [0:0]           s_tuser   = '0;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 m_tlast;
	logic                 cfg_wr_en = 1'b0;
	logic [2:0]           cfg_index = '0;
	logic [17:0]          cfg_wdata = '0;

	stencil_scoreboard sb = new();

	logic [31:0] corner_values [6] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
		32'hFFFF_FFFF, 32'h0000_0001, 32'h0001_0000};

	bit sender_eager  = 1'b0;
	bit sink_eager    = 1'b0;
	bit long_hold_req = 1'b0;
	int sent          = 0;

	advection_stencil_row_engine DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int gap_cycles();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	function automatic logic [31:0] pick_value();
		int unsigned r;
		r = $urandom_range(0, 15);
		if (r < 4)
			return corner_values[r];
		if (r < 10)
			return $urandom();
		return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
	endfunction

	function automatic logic [17:0] pick_coef(int unsigned top);
		case ($urandom_range(0, 7))
			0: return 18'd0;
			1: return 18'(top);
			2: return 18'h3FFFF;
			default: return 18'($urandom_range(0, top));
		endcase
	endfunction

	task automatic config_write(input logic [2:0] idx, input logic [17:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		sb.set_reg(idx, val);
	endtask

	task automatic send_point(input logic [31:0] pv, input logic [31:0] sv, input bit start);
		s_tvalid <= 1'b1;
		s_tdata  <= {sv, pv};
		s_tuser  <= start;
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_point(pv, sv, start);
		sent++;
	endtask

	// block is idle once all results are back and the pipeline has emptied
	task automatic settle();
		s_tvalid <= 1'b0;
		while (sb.waiting() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tlast);

	initial begin : result_sink
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (stall_left == 0 && long_hold_req) begin
				long_hold_req = 1'b0;
				stall_left    = LONG_HOLD;
			end else if (stall_left == 0 && !sink_eager)
				stall_left = gap_cycles();
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else
				m_tready <= 1'b1;
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	initial begin : stimulus
		int          g, i, n, gap, phase;
		int unsigned len;
		logic [17:0] len_val;
		bit          wide_row;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corner values on three-point rows, one grid per scheme;
		// the first grid runs on the reset coefficients
		for (g = 0; g < 4; g++) begin
			case (g)
				0: config_write(REG_ROW_LENGTH, 18'd0);
				1: begin
					config_write(REG_SCHEME_MODE, 18'(MODE_LW));
					config_write(REG_TIME_STEP, 18'h3FFFF);
					config_write(REG_COURANT, 18'h3FFFF);
					config_write(REG_HALF_COURANT, 18'h3FFFF);
					config_write(REG_ROW_LENGTH, 18'd2);
				end
				2: begin
					config_write(REG_SCHEME_MODE, 18'(MODE_LF));
					config_write(REG_TIME_STEP, 18'd0);
					config_write(REG_COURANT, 18'd0);
					config_write(REG_HALF_COURANT, 18'd0);
					config_write(REG_ROW_LENGTH, 18'd3);
				end
				default: begin
					config_write(REG_SCHEME_MODE, 18'(MODE_LEAP));
					config_write(REG_TIME_STEP, 18'd65536);
					config_write(REG_COURANT, 18'd131072);
					config_write(REG_HALF_COURANT, 18'd131072);
				end
			endcase
			cfg_wr_en <= 1'b0;
			// the third grid restarts in the middle of its second row
			for (i = 0; i < 6; i++)
				send_point(corner_values[(i + g) % 6], corner_values[(5 * i + g + 3) % 6],
					(i == 0) || (g == 2 && i == 4));
			settle();
		end

		phase = 0;
		while (sent < ITEM_TARGET) begin
			phase++;
			wide_row     = (phase == 2);
			sender_eager = ($urandom_range(0, 4) == 0);
			sink_eager   = sender_eager;
			case ($urandom_range(0, 9))
				0: len_val = 18'($urandom_range(0, 3));
				1: len_val = 18'($urandom_range(25, 70));
				default: len_val = 18'($urandom_range(4, 24));
			endcase
			if (wide_row)
				len_val = 18'h007FF;
			config_write(REG_SCHEME_MODE, wide_row ? 18'(MODE_LEAP) : 18'($urandom()));
			config_write(REG_TIME_STEP, pick_coef(65536));
			config_write(REG_COURANT, pick_coef(131072));
			config_write(REG_HALF_COURANT, pick_coef(131072));
			config_write(REG_ROW_LENGTH, len_val);
			cfg_wr_en <= 1'b0;

			len = len_val[10:0];
			if (len < 3)
				len = 3;
			if (len > ROW_MAX)
				len = ROW_MAX;
			if (wide_row)
				n = len + 20;
			else
				n = $urandom_range(1, 5) * len + $urandom_range(0, len - 1);

			// receiver holds off while the sender keeps pushing
			if (phase == 4) begin
				long_hold_req = 1'b1;
				sender_eager  = 1'b1;
				if (n < 40)
					n = 40;
			end

			// every new row length starts a fresh grid; rare restarts land mid-row
			for (i = 0; i < n; i++) begin
				send_point(pick_value(), pick_value(), (i == 0) || ($urandom_range(0, 79) == 0));
				if (!sender_eager) begin
					gap = gap_cycles();
					if (gap > 0) begin
						s_tvalid <= 1'b0;
						repeat (gap) @(posedge clk);
					end
				end
			end
			settle();
		end

		if (sb.errors == 0 && sb.waiting() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
